[rtl/ulfsl_pkg.sv]
// Package: item types, register indexes and sizing constants for the function start locator.
package ulfsl_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam int ADDR_W  = 64;
   localparam int SHIFT_W = 7;
   localparam int GROUP_W = 7;

   localparam logic [SHIFT_W-1:0] GROUP_BITS = 7'd7;
   localparam logic [SHIFT_W-1:0] SHIFT_SAT  = 7'd70;
   localparam logic [7:0]         PAYLOAD_MASK = 8'h7F;
   localparam logic [7:0]         MORE_BIT     = 8'h80;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_START     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_END       = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       region_end;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] function_start;
      logic [ADDR_W-1:0] offset_in_function;
      logic              target_in_text;
      logic              truncated_entry;
   } rsp_type;

   // classified byte between front and back
   typedef struct packed {
      logic [GROUP_W-1:0] payload;
      logic               more;
      logic               zero;
      logic               last;
   } cls_type;

   // end-of-region summary from back to response stage
   typedef struct packed {
      logic [ADDR_W-1:0] best_start;
      logic              partial;
   } res_type;

   typedef struct packed {
      logic [ADDR_W-1:0] target_address;
      logic [ADDR_W-1:0] text_start;
      logic [ADDR_W-1:0] text_end;
   } cfg_type;

endpackage

[rtl/ulfsl_front.sv]
// Front stage: accepts input bytes and classifies them into queue items.
module ulfsl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  ulfsl_pkg::req_type req_data,
   output logic              req_full,
   output logic              q_push,
   output ulfsl_pkg::cls_type q_data,
   input  logic              q_full
);
   import ulfsl_pkg::*;

   logic    valid_ff, valid_in;
   cls_type cls_ff, cls_in;
   logic    load;
   logic [7:0] masked;

   assign req_full = valid_ff & q_full;
   assign load     = req_push & ~req_full;
   assign masked   = req_data.data_byte & PAYLOAD_MASK;

   always_comb begin
      cls_in.payload = masked[GROUP_W-1:0];
      cls_in.more    = (req_data.data_byte & MORE_BIT) != 8'h00;
      cls_in.zero    = req_data.data_byte == 8'h00;
      cls_in.last    = req_data.region_end;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !q_full) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         cls_ff <= cls_in;
      end
   end

   assign q_push = valid_ff;
   assign q_data = cls_ff;

endmodule

[rtl/ulfsl_queue.sv]
// Short queue of classified bytes between front and back.
module ulfsl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ulfsl_pkg::cls_type push_data,
   output logic              full,
   input  logic              pop,
   output ulfsl_pkg::cls_type pop_data,
   output logic              empty
);
   import ulfsl_pkg::*;

   cls_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/ulfsl_back.sv]
// Back stage: LEB128 delta decode, running address and function start search.
module ulfsl_back (
   input  logic              clock,
   input  logic              reset,
   input  ulfsl_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  ulfsl_pkg::cls_type q_data,
   output logic              q_pop,
   input  logic              res_ready,
   output logic              res_valid,
   output ulfsl_pkg::res_type res_data
);
   import ulfsl_pkg::*;

   typedef enum logic [1:0] {
      PH_STREAM,
      PH_ENTRY,
      PH_MID,
      PH_STOP
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [ADDR_W-1:0]   running_ff, running_in;
   logic [ADDR_W-1:0]   acc_ff, acc_in;
   logic [SHIFT_W-1:0]  shift_ff, shift_in;
   logic [ADDR_W-1:0]   best_ff, best_in;
   logic                partial_ff, partial_in;

   logic                take;
   logic [ADDR_W-1:0]   base;
   logic [ADDR_W-1:0]   acc_new;
   logic [ADDR_W-1:0]   sum;
   logic [SHIFT_W:0]    shift_sum;

   assign take  = ~q_empty & res_ready;
   assign q_pop = take;

   always_comb begin
      base      = (phase_ff == PH_STREAM) ? cfg.text_start : running_ff;
      acc_new   = acc_ff;
      if (!shift_ff[SHIFT_W-1]) begin
         acc_new = acc_ff | ({{(ADDR_W-GROUP_W){1'b0}}, q_data.payload} << shift_ff[5:0]);
      end
      sum       = base + acc_new;
      shift_sum = {1'b0, shift_ff} + {1'b0, GROUP_BITS};

      phase_in   = phase_ff;
      running_in = running_ff;
      acc_in     = acc_ff;
      shift_in   = shift_ff;
      best_in    = best_ff;
      partial_in = partial_ff;

      unique case (phase_ff) inside
         PH_STOP: begin
         end
         PH_STREAM, PH_ENTRY, PH_MID: begin
            running_in = base;
            if (phase_ff != PH_MID && q_data.zero) begin
               phase_in = PH_STOP;
            end else begin
               shift_in = (shift_sum > {1'b0, SHIFT_SAT}) ? SHIFT_SAT : shift_sum[SHIFT_W-1:0];
               if (q_data.more) begin
                  acc_in     = acc_new;
                  phase_in   = PH_MID;
                  partial_in = 1'b1;
               end else begin
                  running_in = sum;
                  acc_in     = '0;
                  shift_in   = '0;
                  partial_in = 1'b0;
                  if (sum >= cfg.target_address) begin
                     phase_in = PH_STOP;
                  end else begin
                     best_in  = sum;
                     phase_in = PH_ENTRY;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign res_valid           = take & q_data.last;
   assign res_data.best_start = best_in;
   assign res_data.partial    = partial_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_STREAM;
         running_ff <= '0;
         acc_ff     <= '0;
         shift_ff   <= '0;
         best_ff    <= '0;
         partial_ff <= 1'b0;
      end else if (take) begin
         if (q_data.last) begin
            phase_ff   <= PH_STREAM;
            running_ff <= '0;
            acc_ff     <= '0;
            shift_ff   <= '0;
            best_ff    <= '0;
            partial_ff <= 1'b0;
         end else begin
            phase_ff   <= phase_in;
            running_ff <= running_in;
            acc_ff     <= acc_in;
            shift_ff   <= shift_in;
            best_ff    <= best_in;
            partial_ff <= partial_in;
         end
      end
   end

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      shift_ff <= SHIFT_SAT)
      else $error("shift amount above saturation");

   a_stream_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STREAM |-> acc_ff == '0 && shift_ff == '0 && !partial_ff)
      else $error("stream start with leftover entry state");

   a_entry_whole: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ENTRY |-> !partial_ff && acc_ff == '0)
      else $error("entry boundary with partial entry");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      take && q_data.last |=> phase_ff == PH_STREAM)
      else $error("stream not restarted after region end");

endmodule

[rtl/ulfsl_resp.sv]
// Response stage: forms result fields and buffers them for the consumer.
module ulfsl_resp (
   input  logic              clock,
   input  logic              reset,
   input  ulfsl_pkg::cfg_type cfg,
   input  logic              res_valid,
   input  ulfsl_pkg::res_type res_data,
   output logic              res_ready,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ulfsl_pkg::rsp_type rsp_data
);
   import ulfsl_pkg::*;

   logic                 stage_valid_ff, stage_valid_in;
   res_type              stage_ff;
   rsp_type              mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 fifo_full, move, do_pop;
   logic                 in_text;
   rsp_type              formed;

   assign fifo_full = count_ff == RSP_CNT_W'(RSP_DEPTH);
   assign rsp_empty = count_ff == '0;
   assign move      = stage_valid_ff & ~fifo_full;
   assign do_pop    = rsp_pop & ~rsp_empty;
   assign res_ready = ~stage_valid_ff | ~fifo_full;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      in_text = (cfg.target_address >= cfg.text_start) &&
                (cfg.target_address <= cfg.text_end);
      formed.function_start     = in_text ? stage_ff.best_start : '0;
      formed.offset_in_function = in_text ? (cfg.target_address - stage_ff.best_start) : '0;
      formed.target_in_text     = in_text;
      formed.truncated_entry    = stage_ff.partial;

      stage_valid_in = stage_valid_ff;
      if (res_valid) begin
         stage_valid_in = 1'b1;
      end else if (move) begin
         stage_valid_in = 1'b0;
      end

      count_in = count_ff;
      if (move && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !move) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         count_ff       <= count_in;
         if (move) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (res_valid) begin
         stage_ff <= res_data;
      end
      if (move) begin
         mem_ff[wr_ptr_ff] <= formed;
      end
   end

endmodule

[rtl/uleb128_function_start_locator_core.sv]
// Top level: LEB128 function start locator with configuration registers.
// Throughput: one byte per cycle through front, queue and back while res_ready holds.
// A result passes the front register, the queue, the response stage and its buffer.
// The back stage (shift, OR, 64-bit add and compare) sets the one-byte-per-cycle loop.
// Synchronous active-high reset empties all queues and zeroes config and decode state.
module uleb128_function_start_locator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  ulfsl_pkg::req_type              req_data,
   output logic                            req_full,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output ulfsl_pkg::rsp_type              rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ulfsl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ulfsl_pkg::ADDR_W-1:0]    csr_data
);
   import ulfsl_pkg::*;

   cfg_type cfg_ff;
   logic    csr_write;

   logic    fq_push, fq_full, bq_pop, bq_empty;
   cls_type fq_data, bq_data;
   logic    res_valid, res_ready;
   res_type res_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TARGET_ADDRESS: cfg_ff.target_address <= csr_data;
            CSR_TEXT_START:     cfg_ff.text_start     <= csr_data;
            CSR_TEXT_END:       cfg_ff.text_end       <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ulfsl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_push   (fq_push),
      .q_data   (fq_data),
      .q_full   (fq_full)
   );

   ulfsl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_data),
      .full      (fq_full),
      .pop       (bq_pop),
      .pop_data  (bq_data),
      .empty     (bq_empty)
   );

   ulfsl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (bq_empty),
      .q_data    (bq_data),
      .q_pop     (bq_pop),
      .res_ready (res_ready),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   ulfsl_resp u_resp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

[sim/uleb128_function_start_locator_core_test.sv]
// Self-checking testbench for the LEB128 function start locator core.
module uleb128_function_start_locator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ulfsl_pkg::*;

   typedef enum logic [1:0] {SCAN_STREAM, SCAN_ENTRY, SCAN_MID, SCAN_STOP} scan_phase_type;

   class start_locator_model;
      logic [ADDR_W-1:0]  target;
      logic [ADDR_W-1:0]  text_base;
      logic [ADDR_W-1:0]  text_limit;
      logic [ADDR_W-1:0]  run_addr;
      logic [ADDR_W-1:0]  delta;
      logic [ADDR_W-1:0]  best;
      logic [SHIFT_W-1:0] shift;
      scan_phase_type     phase;
      bit                 partial;
      rsp_type            expected_starts[$];
      int                 errors;

      function new();
         target = '0;
         text_base = '0;
         text_limit = '0;
         errors = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         run_addr = '0;
         delta = '0;
         shift = '0;
         best = '0;
         phase = SCAN_STREAM;
         partial = 1'b0;
      endfunction

      function void note_config(logic [CSR_INDEX_W-1:0] idx, logic [ADDR_W-1:0] val);
         case (idx)
            CSR_TARGET_ADDRESS: target = val;
            CSR_TEXT_START:     text_base = val;
            CSR_TEXT_END:       text_limit = val;
            default: ;
         endcase
      endfunction

      function void note_input(req_type it);
         logic [7:0]        b;
         logic [ADDR_W-1:0] grp;
         rsp_type           r;
         bit                in_text;
         b = it.data_byte;
         if (phase != SCAN_STOP) begin
            if (phase == SCAN_STREAM) begin
               run_addr = text_base;
               phase = SCAN_ENTRY;
            end
            if (phase == SCAN_ENTRY && b == 8'h00) begin
               phase = SCAN_STOP;
            end else begin
               if (shift < 64) begin
                  grp = 64'(b & PAYLOAD_MASK);
                  delta = delta | (grp << shift);
               end
               shift = (shift + GROUP_BITS > SHIFT_SAT) ? SHIFT_SAT : shift + GROUP_BITS;
               if ((b & MORE_BIT) != 8'h00) begin
                  phase = SCAN_MID;
                  partial = 1'b1;
               end else begin
                  run_addr = run_addr + delta;
                  delta = '0;
                  shift = '0;
                  partial = 1'b0;
                  if (run_addr >= target) begin
                     phase = SCAN_STOP;
                  end else begin
                     best = run_addr;
                     phase = SCAN_ENTRY;
                  end
               end
            end
         end
         if (it.region_end) begin
            in_text = (target >= text_base) && (target <= text_limit);
            r.function_start = in_text ? best : '0;
            r.offset_in_function = in_text ? target - best : '0;
            r.target_in_text = in_text;
            r.truncated_entry = partial;
            expected_starts.push_back(r);
            clear_stream();
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (expected_starts.size() == 0) begin
            $error("unexpected result: function_start %h offset %h",
                   got.function_start, got.offset_in_function);
            errors++;
            return;
         end
         exp = expected_starts.pop_front();
         if (got.function_start !== exp.function_start) begin
            $error("function_start: expected %h, got %h", exp.function_start, got.function_start);
            errors++;
         end
         if (got.offset_in_function !== exp.offset_in_function) begin
            $error("offset_in_function: expected %h, got %h",
                   exp.offset_in_function, got.offset_in_function);
            errors++;
         end
         if (got.target_in_text !== exp.target_in_text) begin
            $error("target_in_text: expected %b, got %b", exp.target_in_text, got.target_in_text);
            errors++;
         end
         if (got.truncated_entry !== exp.truncated_entry) begin
            $error("truncated_entry: expected %b, got %b", exp.truncated_entry, got.truncated_entry);
            errors++;
         end
      endfunction

      function int pending();
         return expected_starts.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   req_type                req_data = '0;
   logic                   req_full;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_TARGET_ADDRESS;
   logic [ADDR_W-1:0]      csr_data = '0;

   start_locator_model model = new();
   logic [7:0]         stream_bytes[$];
   int                 items_sent = 0;
   bit                 gaps_on = 1'b1;
   int                 hold_cycles = 0;
   int                 rsp_stall_left = 0;

   uleb128_function_start_locator_core dut (.*);

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("** uleb128_function_start_locator_core: FAILED **");
      $finish;
   end

   // result side: random pop stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            model.check_result(rsp_data);
         if (hold_cycles > 0) begin
            rsp_stall_left = hold_cycles - 1;
            hold_cycles = 0;
            rsp_pop <= 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_pop <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_stall_left = $urandom_range(1, 19) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !reset;
         end
      end
   end

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic push_item(logic [7:0] b, logic last);
      req_type it;
      it.data_byte = b;
      it.region_end = last;
      req_data <= it;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      model.note_input(it);
      items_sent++;
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [ADDR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      model.note_config(idx, val);
   endtask

   task automatic load_config(logic [ADDR_W-1:0] tgt, logic [ADDR_W-1:0] lo,
                              logic [ADDR_W-1:0] hi);
      write_reg(CSR_TARGET_ADDRESS, tgt);
      write_reg(CSR_TEXT_START, lo);
      write_reg(CSR_TEXT_END, hi);
      csr_valid <= 1'b0;
   endtask

   // drain, then allow for bytes still in flight that produce no result
   task automatic wait_idle();
      req_push <= 1'b0;
      while (model.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic void add_delta(logic [ADDR_W-1:0] d, int pad);
      logic [6:0] grp[$];
      int         total;
      logic [6:0] g;
      do begin
         grp.push_back(d[6:0]);
         d = d >> 7;
      end while (d != 0);
      total = grp.size() + pad;
      for (int i = 0; i < total; i++) begin
         g = 7'd0;
         if (i < grp.size())
            g = grp[i];
         stream_bytes.push_back({i < total - 1, g});
      end
   endfunction

   // long entry of random groups, runs past the 64-bit shift range
   function automatic void add_raw_entry();
      repeat ($urandom_range(9, 12))
         stream_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
      stream_bytes.push_back({1'b0, 7'($urandom_range(0, 127))});
   endfunction

   function automatic void build_stream(int unsigned scale);
      int pad;
      stream_bytes.delete();
      repeat ($urandom_range(0, 8)) begin
         pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
         case ($urandom_range(0, 19))
            0:       add_delta(rand64(), pad);
            1:       add_delta('0, $urandom_range(1, 3));
            2:       add_raw_entry();
            default: add_delta(64'($urandom_range(1, scale)), pad);
         endcase
      end
      case ($urandom_range(0, 5))
         0: begin
            stream_bytes.push_back(8'h00);
            repeat ($urandom_range(0, 3))
               stream_bytes.push_back(8'($urandom_range(0, 255)));
         end
         1: repeat ($urandom_range(1, 3))
               stream_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
         2: repeat ($urandom_range(1, 3))
               stream_bytes.push_back(8'($urandom_range(0, 255)));
         default: ;
      endcase
      if (stream_bytes.size() == 0)
         stream_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_bytes(bit close);
      foreach (stream_bytes[i])
         push_item(stream_bytes[i], close && i == stream_bytes.size() - 1);
   endtask

   task automatic run_phase(int p);
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] tgt;
      logic [ADDR_W-1:0] hi;
      int unsigned       span;
      int unsigned       scale;
      int                n_streams;
      bit                carry;
      gaps_on = (items_sent < 850) && ($urandom_range(0, 2) != 0);
      case (p)
         0: begin
            lo = '0; tgt = '1; hi = '1; scale = 32'hFFFF_FFFF;
         end
         1: begin
            lo = '1 - 500; tgt = lo + 2000; hi = '1; scale = 300;
         end
         2: begin
            lo = '0; tgt = '0; hi = '0; scale = 100;
         end
         default: begin
            lo = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom);
            span = $urandom_range(1, 5000);
            tgt = lo + span;
            hi = tgt + $urandom;
            scale = span / $urandom_range(1, 10);
            if (scale == 0)
               scale = 1;
            case ($urandom_range(0, 6))
               0: hi = tgt - 1;
               1: hi = tgt;
               2: begin
                  tgt = lo - 1;
                  hi = lo + $urandom;
               end
               3: hi = '1;
               4: begin
                  tgt = lo;
                  hi = lo;
               end
               default: ;
            endcase
         end
      endcase
      load_config(tgt, lo, hi);
      if (p == 3)
         hold_cycles = 300;
      n_streams = (p == 3) ? 20 : $urandom_range(4, 12);
      carry = (p > 3) && ($urandom_range(0, 3) == 0);
      for (int s = 0; s < n_streams; s++) begin
         build_stream(scale);
         send_bytes(!(carry && s == n_streams - 1));
      end
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers still at reset: target zero is inside a text range that holds only address zero
      stream_bytes = '{8'h00};
      send_bytes(1'b1);
      wait_idle();

      load_config(64'h1010, 64'h1000, '1);
      stream_bytes = '{8'h00};
      send_bytes(1'b1);
      stream_bytes = '{8'hFF};
      send_bytes(1'b1);
      // zero byte inside an entry, stop on terminator, ignored bytes after it
      stream_bytes = '{8'h05, 8'h85, 8'h00, 8'h03, 8'h00, 8'h7F, 8'hFF};
      send_bytes(1'b1);
      // first start already at the target: no start below it
      stream_bytes = '{8'h10};
      send_bytes(1'b1);
      // all-ones delta with dropped high bits, wraps the address
      stream_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'hFF, 8'hFF, 8'h80, 8'h01};
      send_bytes(1'b1);
      wait_idle();

      for (int p = 0; items_sent < 950; p++)
         run_phase(p);

      gaps_on = 1'b0;
      wait_idle();
      if (model.errors == 0) begin
         $display("** uleb128_function_start_locator_core: PASSED **");
      end else begin
         $display("** uleb128_function_start_locator_core: FAILED **");
      end
      $finish;
   end

endmodule
